### design/rtwe_pkg.sv
// ----------------------------------------------------------------------------
// Route time-window evaluator package
// Shared widths, request and register codes, and the structs that pass
// configuration and route reports between the evaluator stages.
// ----------------------------------------------------------------------------
package rtwe_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TIME_W      = 32;
	localparam int LOAD_W      = 24;
	localparam int CAP_W       = 15;
	localparam int WINDOW_W    = 24;
	localparam int WEIGHT_W    = 16;
	localparam int STEP_W      = 16;
	localparam int DELTA_W     = 16;
	localparam int OUT_COUNT_W = 16;
	localparam int COST_W      = 52;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// request kinds
	localparam logic REQ_STOP  = 1'b0;
	localparam logic REQ_CLOSE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_CLOSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_W_DURATION  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_W_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_W_CAPACITY  = 3'd4;

	typedef struct packed {
		logic [CAP_W-1:0]    capacity;
		logic [WINDOW_W-1:0] depot_close;
		logic [WEIGHT_W-1:0] w_duration;
		logic [WEIGHT_W-1:0] w_window;
		logic [WEIGHT_W-1:0] w_capacity;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]      duration;
		logic [COUNT_WIDTH-1:0] late;
		logic [COUNT_WIDTH-1:0] over;
	} report_t;

	// Saturating time add
	function automatic logic [TIME_W-1:0] add_time(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// Saturating count increment
	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
	endfunction

endpackage

### design/rtwe_eval.sv
// ----------------------------------------------------------------------------
// Route stop evaluator
// Registers each incoming transaction, walks the route state one stop per
// cycle and hands a report to the cost stage when a route is closed.
// ----------------------------------------------------------------------------
module rtwe_eval (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [rtwe_pkg::STEP_W-1:0]        travel_time,
	input  logic [rtwe_pkg::WINDOW_W-1:0]      open_time,
	input  logic [rtwe_pkg::WINDOW_W-1:0]      close_time,
	input  logic signed [rtwe_pkg::DELTA_W-1:0] load_change,
	input  logic [rtwe_pkg::STEP_W-1:0]        service_time,
	input  rtwe_pkg::cfg_t                     cfg,
	output logic                               rpt_valid,
	input  logic                               rpt_ready,
	output rtwe_pkg::report_t                  rpt
);

	localparam int TW = rtwe_pkg::TIME_W;
	localparam int LW = rtwe_pkg::LOAD_W;
	localparam int CW = rtwe_pkg::COUNT_WIDTH;
	localparam int DW = rtwe_pkg::DELTA_W;

	logic                            valid_s1;
	logic                            type_s1;
	logic [rtwe_pkg::STEP_W-1:0]     travel_s1;
	logic [rtwe_pkg::WINDOW_W-1:0]   open_s1;
	logic [rtwe_pkg::WINDOW_W-1:0]   close_s1;
	logic [DW-1:0]                   delta_s1;
	logic [rtwe_pkg::STEP_W-1:0]     service_s1;

	logic [TW-1:0] elapsed_q;
	logic [LW-1:0] load_q;
	logic [CW-1:0] late_q;
	logic [CW-1:0] over_q;

	logic              rpt_valid_q;
	rtwe_pkg::report_t rpt_q;

	logic          is_close;
	logic          s1_fire;
	logic [TW-1:0] t_arrive;
	logic [TW-1:0] t_start;
	logic [TW-1:0] t_leave;
	logic          late_hit;
	logic [CW-1:0] late_next;
	logic [LW:0]   load_sum;
	logic [LW-1:0] load_next;
	logic          over_hit;

	assign is_close = (type_s1 == rtwe_pkg::REQ_CLOSE);
	// a close transaction needs room in the report register
	assign s1_fire  = valid_s1 && (!is_close || !rpt_valid_q || rpt_ready);
	assign in_ready = !valid_s1 || s1_fire;

	// time walk: arrive, check window, wait for open, serve
	always_comb begin
		t_arrive = rtwe_pkg::add_time(elapsed_q, TW'(travel_s1));
		if (is_close) begin
			late_hit = t_arrive > TW'(cfg.depot_close);
		end else begin
			late_hit = t_arrive > TW'(close_s1);
		end
		t_start   = (t_arrive < TW'(open_s1)) ? TW'(open_s1) : t_arrive;
		t_leave   = rtwe_pkg::add_time(t_start, TW'(service_s1));
		late_next = late_hit ? rtwe_pkg::bump(late_q) : late_q;
	end

	// load walk with saturation to the signed load range
	always_comb begin
		load_sum = {load_q[LW-1], load_q} + {{(LW+1-DW){delta_s1[DW-1]}}, delta_s1};
		if (load_sum[LW] != load_sum[LW-1]) begin
			load_next = load_sum[LW] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
		end else begin
			load_next = load_sum[LW-1:0];
		end
		over_hit = load_next[LW-1] || (load_next > LW'(cfg.capacity));
	end

	// hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			type_s1    <= req_type;
			travel_s1  <= travel_time;
			open_s1    <= open_time;
			close_s1   <= close_time;
			delta_s1   <= load_change;
			service_s1 <= service_time;
		end
	end

	// advance the route state; clear it on close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			load_q    <= '0;
			late_q    <= '0;
			over_q    <= '0;
		end else if (s1_fire) begin
			if (is_close) begin
				elapsed_q <= '0;
				load_q    <= '0;
				late_q    <= '0;
				over_q    <= '0;
			end else begin
				elapsed_q <= t_leave;
				load_q    <= load_next;
				late_q    <= late_next;
				over_q    <= over_hit ? rtwe_pkg::bump(over_q) : over_q;
			end
		end
	end

	// report register toward the cost stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (s1_fire && is_close) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt_ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && is_close) begin
			rpt_q.duration <= t_arrive;
			rpt_q.late     <= late_next;
			rpt_q.over     <= over_q;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

### design/rtwe_cost.sv
// ----------------------------------------------------------------------------
// Route cost stage
// Multiplies the route report by the cost weights, sums the products and
// holds the finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module rtwe_cost (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rtwe_pkg::cfg_t                        cfg,
	input  logic                                  rpt_valid,
	output logic                                  rpt_ready,
	input  rtwe_pkg::report_t                     rpt,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rtwe_pkg::TIME_W-1:0]           duration,
	output logic [rtwe_pkg::OUT_COUNT_W-1:0]      window_violations,
	output logic [rtwe_pkg::OUT_COUNT_W-1:0]      capacity_violations,
	output logic [rtwe_pkg::COST_W-1:0]           route_cost
);

	localparam int TW  = rtwe_pkg::TIME_W;
	localparam int CW  = rtwe_pkg::COUNT_WIDTH;
	localparam int WW  = rtwe_pkg::WEIGHT_W;
	localparam int OCW = rtwe_pkg::OUT_COUNT_W;
	localparam int KW  = rtwe_pkg::COST_W;
	localparam int XW  = CW + OCW;

	logic              valid_s3;
	logic [TW+WW-1:0]  p_dur_s3;
	logic [CW+WW-1:0]  p_win_s3;
	logic [CW+WW-1:0]  p_cap_s3;
	logic [TW-1:0]     dur_s3;
	logic [OCW-1:0]    win_s3;
	logic [OCW-1:0]    cap_s3;

	logic              out_valid_q;
	logic [TW-1:0]     dur_q;
	logic [OCW-1:0]    win_q;
	logic [OCW-1:0]    cap_q;
	logic [KW-1:0]     cost_q;

	logic s3_adv;

	// Clip a route count to the report field width
	function automatic logic [OCW-1:0] clip_count(input logic [CW-1:0] c);
		logic [XW-1:0] wide;
		logic [XW-1:0] limit;
		wide  = XW'(c);
		limit = XW'({OCW{1'b1}});
		return (wide > limit) ? {OCW{1'b1}} : wide[OCW-1:0];
	endfunction

	assign s3_adv    = valid_s3 && (!out_valid_q || out_ready);
	assign rpt_ready = !valid_s3 || s3_adv;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rpt_ready) begin
			valid_s3 <= rpt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_ready && rpt_valid) begin
			p_dur_s3 <= (TW+WW)'(rpt.duration) * (TW+WW)'(cfg.w_duration);
			p_win_s3 <= (CW+WW)'(rpt.late) * (CW+WW)'(cfg.w_window);
			p_cap_s3 <= (CW+WW)'(rpt.over) * (CW+WW)'(cfg.w_capacity);
			dur_s3   <= rpt.duration;
			win_s3   <= clip_count(rpt.late);
			cap_s3   <= clip_count(rpt.over);
		end
	end

	// output register: sum the weighted terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			dur_q  <= dur_s3;
			win_q  <= win_s3;
			cap_q  <= cap_s3;
			cost_q <= KW'(p_dur_s3) + KW'(p_win_s3) + KW'(p_cap_s3);
		end
	end

	assign out_valid           = out_valid_q;
	assign duration            = dur_q;
	assign window_violations   = win_q;
	assign capacity_violations = cap_q;
	assign route_cost          = cost_q;

endmodule

### design/route_time_window_evaluator_top.sv
// ----------------------------------------------------------------------------
// Route time-window evaluator
// Walks a vehicle route stop by stop and reports duration, window and
// capacity violation counts and a weighted cost on each close transaction.
// ----------------------------------------------------------------------------
// Path: a close transaction is held in the input register from acceptance,
//   then moves through the report, product and output registers.
// Throughput: one transaction per cycle unless out_ready back-pressure stalls
//   it; the route state update in the input-register stage sets this rate.
// Reset: arst_n clears the route state and pipeline valids and loads the
//   configuration registers with their defaults; no clearing pass.
module route_time_window_evaluator_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   req_type,
	input  logic [rtwe_pkg::STEP_W-1:0]            travel_time,
	input  logic [rtwe_pkg::WINDOW_W-1:0]          open_time,
	input  logic [rtwe_pkg::WINDOW_W-1:0]          close_time,
	input  logic signed [rtwe_pkg::DELTA_W-1:0]    load_change,
	input  logic [rtwe_pkg::STEP_W-1:0]            service_time,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rtwe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rtwe_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [rtwe_pkg::TIME_W-1:0]            duration,
	output logic [rtwe_pkg::OUT_COUNT_W-1:0]       window_violations,
	output logic [rtwe_pkg::OUT_COUNT_W-1:0]       capacity_violations,
	output logic [rtwe_pkg::COST_W-1:0]            route_cost
);

	rtwe_pkg::cfg_t    cfg_q;
	logic              rpt_valid;
	logic              rpt_ready;
	rtwe_pkg::report_t rpt;

	assign cfg_ready = 1'b1;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity    <= '0;
			cfg_q.depot_close <= {rtwe_pkg::WINDOW_W{1'b1}};
			cfg_q.w_duration  <= rtwe_pkg::WEIGHT_W'(1);
			cfg_q.w_window    <= '0;
			cfg_q.w_capacity  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rtwe_pkg::CFG_CAPACITY: begin
					cfg_q.capacity <= cfg_data[rtwe_pkg::CAP_W-1:0];
				end
				rtwe_pkg::CFG_DEPOT_CLOSE: begin
					cfg_q.depot_close <= cfg_data[rtwe_pkg::WINDOW_W-1:0];
				end
				rtwe_pkg::CFG_W_DURATION: begin
					cfg_q.w_duration <= cfg_data[rtwe_pkg::WEIGHT_W-1:0];
				end
				rtwe_pkg::CFG_W_WINDOW: begin
					cfg_q.w_window <= cfg_data[rtwe_pkg::WEIGHT_W-1:0];
				end
				rtwe_pkg::CFG_W_CAPACITY: begin
					cfg_q.w_capacity <= cfg_data[rtwe_pkg::WEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rtwe_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.travel_time  (travel_time),
		.open_time    (open_time),
		.close_time   (close_time),
		.load_change  (load_change),
		.service_time (service_time),
		.cfg          (cfg_q),
		.rpt_valid    (rpt_valid),
		.rpt_ready    (rpt_ready),
		.rpt          (rpt)
	);

	rtwe_cost u_cost (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.rpt_valid           (rpt_valid),
		.rpt_ready           (rpt_ready),
		.rpt                 (rpt),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.duration            (duration),
		.window_violations   (window_violations),
		.capacity_violations (capacity_violations),
		.route_cost          (route_cost)
	);

endmodule
